// ===== hw/rtl/greedy_change_dispenser_unit_macros.svh =====
// assertion macros for the change dispenser
// used by files that check their own logic, expects clk and rst in scope
`ifndef GREEDY_CHANGE_DISPENSER_UNIT_MACROS_SVH
`define GREEDY_CHANGE_DISPENSER_UNIT_MACROS_SVH

// property that must hold at every edge out of reset
`define GCD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the same cycle
`define GCD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent in one cycle implies consequent in the next cycle
`define GCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/gcdisp_pkg.sv =====
// shared types, constants and reset values for the change dispenser
// no dependencies
package gcdisp_pkg;

  localparam int NUM_REGS        = 6;
  localparam int VALUE_W         = 10;
  localparam int AMOUNT_W        = 16;
  localparam int COUNT_W         = 16;
  localparam int SLOT_W          = 3;
  localparam int MODE_W          = 2;
  localparam int CFG_IDX_W       = 3;
  localparam int DEF_NUM_DENOMS  = 6;
  localparam int DEF_AMOUNT_BITS = 16;

  localparam logic [COUNT_W-1:0] STOCK_MAX = '1;

  localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEPOSIT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CHANGE  = 2'd2;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_SHORT = 1'b1;

  typedef enum logic [2:0] {
    CELL_IDLE,
    CELL_DIV,
    CELL_CAP,
    CELL_MUL,
    CELL_SUB
  } cell_state_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_ECHO,
    ST_START,
    ST_WALK,
    ST_FAIL,
    ST_COMMIT,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic               load;
    logic               deposit;
    logic               commit;
    logic [COUNT_W-1:0] load_value;
  } cell_ctl_t;

  function automatic logic [VALUE_W-1:0] denom_reset(input int idx);
    logic [VALUE_W-1:0] v;
    case (idx)
      0: v = 10'd1;
      1: v = 10'd5;
      2: v = 10'd10;
      3: v = 10'd20;
      4: v = 10'd50;
      5: v = 10'd100;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/greedy_change_dispenser_unit.sv =====
// Load and deposit: the slot's stock is updated, then its new count is the result;
// an unknown mode, or a load or deposit to a slot past NUM_DENOMS-1, is taken with no result.
// Change: the amount runs down the slots through the one-bit-per-cycle divider in each; a
// shortfall gives a SHORT result, else the takes follow one per cycle while out_ready allows.
// One item at a time: the next input is taken once the last result is registered.
// Synchronous reset clears all stock counts and restores face values 1,5,10,20,50,100.
`include "greedy_change_dispenser_unit_macros.svh"
module greedy_change_dispenser_unit #(
  parameter int NUM_DENOMS  = gcdisp_pkg::DEF_NUM_DENOMS,
  parameter int AMOUNT_BITS = gcdisp_pkg::DEF_AMOUNT_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [gcdisp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gcdisp_pkg::VALUE_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [gcdisp_pkg::MODE_W-1:0]     mode,
  input  logic [gcdisp_pkg::SLOT_W-1:0]     slot,
  input  logic [gcdisp_pkg::AMOUNT_W-1:0]   amount,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [gcdisp_pkg::SLOT_W-1:0]     slot_out,
  output logic [gcdisp_pkg::COUNT_W-1:0]    coin_count,
  output logic                              status,
  output logic [gcdisp_pkg::AMOUNT_W-1:0]   remaining,
  output logic                              last
);
  import gcdisp_pkg::*;

  localparam int SW = (NUM_DENOMS > 1) ? $clog2(NUM_DENOMS) : 1;
  localparam logic [AMOUNT_W-1:0] AMT_MASK =
    (AMOUNT_BITS >= AMOUNT_W) ? '1 : AMOUNT_W'((64'd1 << AMOUNT_BITS) - 64'd1);

  ctrl_state_t state, state_next;

  logic [MODE_W-1:0]      mode_q;
  logic [SLOT_W-1:0]      slot_q;
  logic [AMOUNT_W-1:0]    amount_q;
  logic [AMOUNT_BITS-1:0] rem_q;
  logic [SW-1:0]          idx, idx_next;

  logic                   upd, go, commit, out_load, out_free, in_xfer;
  logic [SLOT_W-1:0]      o_slot;
  logic [COUNT_W-1:0]     o_count;
  logic                   o_status, o_last;
  logic [AMOUNT_W-1:0]    o_rem;

  logic [NUM_DENOMS:0]    link_go;
  logic [AMOUNT_BITS-1:0] link_rem [NUM_DENOMS+1];
  logic [COUNT_W-1:0]     stock_q [NUM_DENOMS];
  logic [COUNT_W-1:0]     take_q [NUM_DENOMS];
  cell_ctl_t              ctl [NUM_DENOMS];

  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign link_go[NUM_DENOMS]  = go;
  assign link_rem[NUM_DENOMS] = AMOUNT_BITS'(amount_q);

  for (genvar i = 0; i < NUM_DENOMS; i++) begin : g_cell
    always_comb begin
      ctl[i].load       = upd && mode_q == MODE_LOAD && slot_q == SLOT_W'(i);
      ctl[i].deposit    = upd && mode_q == MODE_DEPOSIT && slot_q == SLOT_W'(i);
      ctl[i].commit     = commit;
      ctl[i].load_value = amount_q;
    end

    gcdisp_cell #(
      .IDX         (i),
      .AMOUNT_BITS (AMOUNT_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cfg_write (cfg_write),
      .cfg_index (cfg_index),
      .cfg_data  (cfg_data),
      .ctl       (ctl[i]),
      .start     (link_go[i+1]),
      .rem_in    (link_rem[i+1]),
      .done      (link_go[i]),
      .rem_out   (link_rem[i]),
      .stock     (stock_q[i]),
      .take      (take_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mode_q   <= mode;
      slot_q   <= slot;
      amount_q <= amount & AMT_MASK;
    end
    if (state == ST_WALK && link_go[0]) begin
      rem_q <= link_rem[0];
    end
    idx <= idx_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    in_ready   = 1'b0;
    upd        = 1'b0;
    go         = 1'b0;
    commit     = 1'b0;
    out_load   = 1'b0;
    o_slot     = '0;
    o_count    = '0;
    o_status   = STATUS_OK;
    o_rem      = '0;
    o_last     = 1'b1;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (mode)
            MODE_LOAD, MODE_DEPOSIT: begin
              if ({1'b0, slot} < (SLOT_W+1)'(NUM_DENOMS)) begin
                state_next = ST_UPDATE;
              end
            end
            MODE_CHANGE: state_next = ST_START;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_UPDATE: begin
        upd        = 1'b1;
        state_next = ST_ECHO;
      end
      ST_ECHO: begin
        if (out_free) begin
          out_load   = 1'b1;
          o_slot     = slot_q;
          o_count    = stock_q[slot_q[SW-1:0]];
          state_next = ST_IDLE;
        end
      end
      ST_START: begin
        go         = 1'b1;
        state_next = ST_WALK;
      end
      ST_WALK: begin
        if (link_go[0]) begin
          state_next = (link_rem[0] == '0) ? ST_COMMIT : ST_FAIL;
        end
      end
      ST_FAIL: begin
        if (out_free) begin
          out_load   = 1'b1;
          o_status   = STATUS_SHORT;
          o_rem      = AMOUNT_W'(rem_q);
          state_next = ST_IDLE;
        end
      end
      ST_COMMIT: begin
        commit     = 1'b1;
        idx_next   = SW'(NUM_DENOMS - 1);
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          o_slot   = SLOT_W'(idx);
          o_count  = take_q[idx];
          o_last   = (idx == '0);
          if (idx == '0) begin
            state_next = ST_IDLE;
          end else begin
            idx_next = idx - SW'(1);
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      slot_out   <= o_slot;
      coin_count <= o_count;
      status     <= o_status;
      remaining  <= o_rem;
      last       <= o_last;
    end
  end

  `GCD_ASSERT_ALWAYS(a_one_hop, $onehot0(link_go), "more than one transfer on the chain")
  `GCD_ASSERT_IMPL(a_done_in_walk, link_go[0], state == ST_WALK, "chain done outside a walk")
  `GCD_ASSERT_IMPL(a_commit_exact, state == ST_COMMIT, rem_q == '0, "commit with unpaid amount")
  `GCD_ASSERT_IMPL(a_no_overwrite, out_load, out_valid == 1'b0 || out_ready, "result overwritten")
  `GCD_ASSERT_NEXT(a_emit_done, state == ST_EMIT && out_free && idx == '0, state == ST_IDLE, "emit overran")

endmodule

// ===== hw/rtl/gcdisp_cell.sv =====
// one denomination slot: stock count, face value and a bit-serial divider
// takes the remaining amount from the slot above and hands it to the slot below
// depends on gcdisp_pkg
module gcdisp_cell #(
  parameter int IDX         = 0,
  parameter int AMOUNT_BITS = gcdisp_pkg::DEF_AMOUNT_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [gcdisp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gcdisp_pkg::VALUE_W-1:0]    cfg_data,
  input  gcdisp_pkg::cell_ctl_t             ctl,
  input  logic                              start,
  input  logic [AMOUNT_BITS-1:0]            rem_in,
  output logic                              done,
  output logic [AMOUNT_BITS-1:0]            rem_out,
  output logic [gcdisp_pkg::COUNT_W-1:0]    stock,
  output logic [gcdisp_pkg::COUNT_W-1:0]    take
);
  import gcdisp_pkg::*;

  localparam int CW     = $clog2(AMOUNT_BITS);
  localparam int PROD_W = COUNT_W + VALUE_W;
  localparam int MW     = (AMOUNT_BITS > COUNT_W) ? AMOUNT_BITS : COUNT_W;
  localparam int DW     = (AMOUNT_BITS > PROD_W) ? AMOUNT_BITS : PROD_W;

  cell_state_t state, state_next;

  logic [VALUE_W-1:0]     value;
  logic [AMOUNT_BITS-1:0] quo;
  logic [AMOUNT_BITS-1:0] saved;
  logic [VALUE_W-1:0]     part;
  logic [CW-1:0]          cnt;
  logic [PROD_W-1:0]      prod;
  logic [VALUE_W:0]       trial;
  logic                   fits;
  logic [COUNT_W-1:0]     take_min;

  // face value register, slots past the register list stay at zero
  if (IDX < NUM_REGS) begin : g_value
    always_ff @(posedge clk) begin
      if (rst) begin
        value <= denom_reset(IDX);
      end else if (cfg_write && cfg_index == CFG_IDX_W'(IDX)) begin
        value <= cfg_data;
      end
    end
  end else begin : g_no_value
    assign value = '0;
  end

  // restoring division step, one quotient bit per cycle
  assign trial    = {part, quo[AMOUNT_BITS-1]};
  assign fits     = trial >= {1'b0, value};
  assign take_min = (MW'(quo) <= MW'(stock)) ? COUNT_W'(MW'(quo)) : stock;

  always_ff @(posedge clk) begin
    if (rst) begin
      stock <= '0;
    end else if (ctl.load) begin
      stock <= ctl.load_value;
    end else if (ctl.deposit) begin
      if (stock != STOCK_MAX) begin
        stock <= stock + COUNT_W'(1);
      end
    end else if (ctl.commit) begin
      stock <= stock - take;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      CELL_IDLE: begin
        if (start) begin
          quo   <= rem_in;
          saved <= rem_in;
          part  <= '0;
          cnt   <= '0;
        end
      end
      CELL_DIV: begin
        quo  <= {quo[AMOUNT_BITS-2:0], fits};
        part <= fits ? VALUE_W'(trial - {1'b0, value}) : trial[VALUE_W-1:0];
        cnt  <= cnt + CW'(1);
      end
      CELL_CAP: begin
        take <= (value == '0) ? '0 : take_min;
      end
      CELL_MUL: begin
        prod <= PROD_W'(take) * PROD_W'(value);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CELL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    done       = 1'b0;
    case (state)
      CELL_IDLE: begin
        if (start) begin
          state_next = CELL_DIV;
        end
      end
      CELL_DIV: begin
        if (cnt == CW'(AMOUNT_BITS - 1)) begin
          state_next = CELL_CAP;
        end
      end
      CELL_CAP: state_next = CELL_MUL;
      CELL_MUL: state_next = CELL_SUB;
      CELL_SUB: begin
        done       = 1'b1;
        state_next = CELL_IDLE;
      end
      default: state_next = CELL_IDLE;
    endcase
  end

  // product never exceeds the amount that entered the cell
  assign rem_out = AMOUNT_BITS'(DW'(saved) - DW'(prod));

endmodule
